FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 engine modules.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Initial chaining values A..D
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // First padding byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Byte position facts used by the controller
  localparam logic [5:0] POS_LAST   = 6'd63;
  localparam logic [5:0] POS_BEFORE_LEN = 6'd55;
  localparam logic [1:0] WORD_LAST  = 2'd3;

  // Per-round additive constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round mod 4}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_CHAIN,
    ST_OUTPUT
  } md5_state_t;

  // Source of the byte written into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      byte_we;
    byte_src_t byte_src;
    logic      count_len;
    logic      load_work;
    logic      round_en;
    logic      chain_add;
    logic      word_adv;
    logic      restart;
  } md5_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pos_last;
    logic pos_before_len;
    logic round_last;
    logic word_last;
  } md5_sts_t;

  // Message word used by a round
  function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
    logic [3:0] n;
    logic [3:0] idx;
    n = r[3:0];
    unique case (r[5:4])
      2'd0:    idx = n;
      2'd1:    idx = 4'(n * 4'd5 + 4'd1);
      2'd2:    idx = 4'(n * 4'd3 + 4'd5);
      default: idx = 4'(n * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

FILE: hdl/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, padding, round run, chaining add, digest readout.
// ----------------------------------------------------------------------------
module md5_ctrl import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     has_byte,
  input  logic     end_of_message,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  md5_sts_t sts,
  output md5_cmd_t cmd
);

  md5_state_t state, state_next;
  md5_state_t ret_state, ret_state_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Next state; ret_state says where to go after a block is compressed
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (has_byte && sts.pos_last) begin
            state_next     = ST_ROUND;
            ret_state_next = end_of_message ? ST_PAD_MARK : ST_IDLE;
          end else if (end_of_message) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        if (sts.pos_last) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_PAD_ZERO;
        end else if (sts.pos_before_len) begin
          state_next = ST_PAD_LEN;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (sts.pos_last) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_PAD_ZERO;
        end else if (sts.pos_before_len) begin
          state_next = ST_PAD_LEN;
        end
      end
      ST_PAD_LEN: begin
        if (sts.pos_last) begin
          state_next     = ST_ROUND;
          ret_state_next = ST_OUTPUT;
        end
      end
      ST_ROUND: begin
        if (sts.round_last) begin
          state_next = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        state_next = ret_state;
      end
      ST_OUTPUT: begin
        if (out_ready && sts.word_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.byte_src = SRC_DATA;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.byte_we   = in_valid && has_byte;
        cmd.count_len = in_valid && has_byte;
        cmd.load_work = in_valid && has_byte && sts.pos_last;
      end
      ST_PAD_MARK: begin
        cmd.byte_we   = 1'b1;
        cmd.byte_src  = SRC_MARK;
        cmd.load_work = sts.pos_last;
      end
      ST_PAD_ZERO: begin
        cmd.byte_we   = 1'b1;
        cmd.byte_src  = SRC_ZERO;
        cmd.load_work = sts.pos_last;
      end
      ST_PAD_LEN: begin
        cmd.byte_we   = 1'b1;
        cmd.byte_src  = SRC_LEN;
        cmd.load_work = sts.pos_last;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      ST_CHAIN: begin
        cmd.chain_add = 1'b1;
      end
      ST_OUTPUT: begin
        out_valid    = 1'b1;
        cmd.word_adv = out_ready;
        cmd.restart  = out_ready && sts.word_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/md5_datapath.sv
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, length counter, round unit, chaining words and digest mux.
// ----------------------------------------------------------------------------
module md5_datapath import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  md5_cmd_t    cmd,
  output md5_sts_t    sts,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  logic [31:0] blk [16];
  logic [31:0] chain [4];
  logic [31:0] work [4];
  logic [5:0]  byte_pos;
  logic [63:0] bit_length;
  logic [5:0]  round_cnt;
  logic [1:0]  word_idx;

  logic [7:0]  wr_byte;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [4:0]  rot;
  logic [31:0] rot_val;

  // Select the byte to store
  always_comb begin
    case (cmd.byte_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_MARK: wr_byte = PAD_MARK;
      SRC_ZERO: wr_byte = 8'h00;
      default:  wr_byte = bit_length[{byte_pos[2:0], 3'b000} +: 8];
    endcase
  end

  // Store bytes little-endian into the block buffer
  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      blk[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // Advance byte position and message length
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      bit_length <= '0;
    end else begin
      if (cmd.byte_we) begin
        byte_pos <= byte_pos + 6'd1;
      end
      if (cmd.restart) begin
        bit_length <= '0;
      end else if (cmd.count_len) begin
        bit_length <= bit_length + 64'd8;
      end
    end
  end

  // Round function
  always_comb begin
    case (round_cnt[5:4])
      2'd0:    f_val = (work[1] & work[2]) | (~work[1] & work[3]);
      2'd1:    f_val = (work[3] & work[1]) | (~work[3] & work[2]);
      2'd2:    f_val = work[1] ^ work[2] ^ work[3];
      default: f_val = work[2] ^ (work[1] | ~work[3]);
    endcase
    t_sum   = f_val + work[0] + ROUND_K[round_cnt] + blk[md5_msg_index(round_cnt)];
    rot     = ROT_S[{round_cnt[5:4], round_cnt[1:0]}];
    rot_val = (t_sum << rot) | (t_sum >> (6'd32 - {1'b0, rot}));
  end

  // Working registers: load from chain, then one round a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      round_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        work[i] <= '0;
      end
    end else if (cmd.load_work) begin
      round_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        work[i] <= chain[i];
      end
    end else if (cmd.round_en) begin
      round_cnt <= round_cnt + 6'd1;
      work[0]   <= work[3];
      work[1]   <= work[1] + rot_val;
      work[2]   <= work[1];
      work[3]   <= work[2];
    end
  end

  // Chaining words: fold in each block, restart after readout
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      chain[0] <= IV_A;
      chain[1] <= IV_B;
      chain[2] <= IV_C;
      chain[3] <= IV_D;
    end else if (cmd.chain_add) begin
      for (int i = 0; i < 4; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

  // Digest word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx <= '0;
    end else if (cmd.word_adv) begin
      word_idx <= word_idx + 2'd1;
    end
  end

  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == WORD_LAST);

  assign sts.pos_last       = (byte_pos == POS_LAST);
  assign sts.pos_before_len = (byte_pos == POS_BEFORE_LEN);
  assign sts.round_last     = (round_cnt == 6'd63);
  assign sts.word_last      = (word_idx == WORD_LAST);

endmodule

FILE: hdl/md5_hash_engine.sv
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 digest over a byte stream, one message byte per input item.
//
// Input channel (in_valid/in_ready): data_byte, has_byte, end_of_message.
// A byte item is taken while in_ready is high. The item that fills a
// 64-byte block starts a compression: 64 rounds, one per cycle, then
// the chaining add, and in_ready stays low through them.
// An item with end_of_message set starts padding: one pad byte per cycle
// (0x80, zero fill, 8 length bytes; 9 to 72 bytes in all), paused while a
// full block is compressed. Then the output channel (out_valid/out_ready)
// gives four items, digest words A..D with word_index 0..3 and last_word
// on D. A stalled receiver holds the current word; no input is taken
// until the last word is accepted, which restarts the engine for the
// next message. An item with neither a byte nor end_of_message is
// accepted and dropped. Reset loads the initial chaining values and
// clears the byte position and message length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5_hash_engine import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md5_cmd_t cmd;
  md5_sts_t sts;

  // Sequencer
  md5_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Datapath
  md5_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // Intake and readout never overlap
  `ASSERT_NEVER(a_no_overlap, in_ready && out_valid, "input and output active together")
  // Rounds run only while intake is closed
  `ASSERT_IMPLIES(a_round_busy, cmd.round_en, !in_ready, "round step while accepting input")
  // Last digest word returns the engine to intake at word A
  `ASSERT_NEXT(a_restart, out_valid && out_ready && last_word,
    in_ready && (word_index == 2'd0), "no clean restart after digest")

endmodule
